### rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg
// shared types, token codes and character helpers for the keyword token lexer
// ----------------------------------------------------------------------------
package kwl_pkg;

    // token kinds
    localparam logic [3:0] K_ID    = 4'd0;
    localparam logic [3:0] K_STR   = 4'd1;
    localparam logic [3:0] K_INT   = 4'd2;
    localparam logic [3:0] K_PLUS  = 4'd3;
    localparam logic [3:0] K_STAR  = 4'd4;
    localparam logic [3:0] K_LSQ   = 4'd5;
    localparam logic [3:0] K_RSQ   = 4'd6;
    localparam logic [3:0] K_PRINT = 4'd7;
    localparam logic [3:0] K_SET   = 4'd8;
    localparam logic [3:0] K_SEMI  = 4'd9;
    localparam logic [3:0] K_LPAR  = 4'd10;
    localparam logic [3:0] K_RPAR  = 4'd11;
    localparam logic [3:0] K_DONE  = 4'd12;
    localparam logic [3:0] K_ERR   = 4'd13;

    // word classes
    localparam logic [1:0] WC_NONE   = 2'd0;
    localparam logic [1:0] WC_LETTER = 2'd1;
    localparam logic [1:0] WC_DIGIT  = 2'd2;
    localparam logic [1:0] WC_OTHER  = 2'd3;

    // keyword prefix tracking
    localparam logic [3:0] KW_NONE  = 4'd0;
    localparam logic [3:0] KW_P     = 4'd1;
    localparam logic [3:0] KW_PR    = 4'd2;
    localparam logic [3:0] KW_PRI   = 4'd3;
    localparam logic [3:0] KW_PRIN  = 4'd4;
    localparam logic [3:0] KW_PRINT = 4'd5;
    localparam logic [3:0] KW_S     = 4'd6;
    localparam logic [3:0] KW_SE    = 4'd7;
    localparam logic [3:0] KW_SET   = 4'd8;

    // characters
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_LSQ   = 8'h5B;
    localparam logic [7:0] C_RSQ   = 8'h5D;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_LO_P  = 8'h70;
    localparam logic [7:0] C_LO_R  = 8'h72;
    localparam logic [7:0] C_LO_I  = 8'h69;
    localparam logic [7:0] C_LO_N  = 8'h6E;
    localparam logic [7:0] C_LO_T  = 8'h74;
    localparam logic [7:0] C_LO_S  = 8'h73;
    localparam logic [7:0] C_LO_E  = 8'h65;

    localparam logic [7:0]  MAX_LEXEME = 8'd255;
    localparam logic [15:0] MAX_LINE   = 16'hFFFF;

    // token fifo depth, room for the worst case of three tokens per item
    localparam int          QDEPTH  = 4;
    localparam logic [2:0]  Q_LIMIT = 3'd1;

    typedef struct packed {
        logic        in_str;
        logic        in_cmt;
        logic [1:0]  wclass;
        logic [7:0]  wlen;
        logic [3:0]  kwp;
        logic        held_slash;
        logic        prev_cr;
        logic [15:0] line;
    } t_lex_state;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  len;
        logic [15:0] line;
        logic        last;
    } t_token;

    typedef struct packed {
        t_lex_state st;
        logic [1:0] n;
        t_token     t0;
        t_token     t1;
    } t_plain_res;

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v != MAX_LEXEME) ? v + 8'd1 : v;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
    endfunction

    function automatic logic [1:0] char_class(logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return WC_LETTER;
        if (c >= 8'h30 && c <= 8'h39) return WC_DIGIT;
        return WC_OTHER;
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return (c == C_SEMI) || (c == C_PLUS) || (c == C_STAR) || (c == C_LSQ) ||
               (c == C_RSQ) || (c == C_LPAR) || (c == C_RPAR);
    endfunction

    function automatic logic [3:0] special_kind(logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            C_SEMI:  k = K_SEMI;
            C_PLUS:  k = K_PLUS;
            C_STAR:  k = K_STAR;
            C_LSQ:   k = K_LSQ;
            C_RSQ:   k = K_RSQ;
            C_LPAR:  k = K_LPAR;
            C_RPAR:  k = K_RPAR;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] kw_start(logic [7:0] c);
        if (c == C_LO_P) return KW_P;
        if (c == C_LO_S) return KW_S;
        return KW_NONE;
    endfunction

    function automatic logic [3:0] kw_next(logic [3:0] p, logic [7:0] c);
        if (p == KW_P    && c == C_LO_R) return KW_PR;
        if (p == KW_PR   && c == C_LO_I) return KW_PRI;
        if (p == KW_PRI  && c == C_LO_N) return KW_PRIN;
        if (p == KW_PRIN && c == C_LO_T) return KW_PRINT;
        if (p == KW_S    && c == C_LO_E) return KW_SE;
        if (p == KW_SE   && c == C_LO_T) return KW_SET;
        return KW_NONE;
    endfunction

    function automatic t_token make_tok(logic [3:0] kind, logic [7:0] len,
                                        logic [15:0] line);
        t_token t;
        t.kind = kind;
        t.len  = len;
        t.line = line;
        t.last = 1'b0;
        return t;
    endfunction

    // classification of the pending word
    function automatic logic [3:0] word_kind(t_lex_state s);
        logic [3:0] k;
        unique case (s.wclass)
            WC_LETTER: k = (s.kwp == KW_PRINT) ? K_PRINT :
                           (s.kwp == KW_SET)   ? K_SET : K_ID;
            WC_DIGIT:  k = K_INT;
            default:   k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic t_lex_state clear_word(t_lex_state s);
        t_lex_state r;
        r        = s;
        r.wclass = WC_NONE;
        r.wlen   = 8'd0;
        r.kwp    = KW_NONE;
        return r;
    endfunction

    // one character outside strings and comments: up to two tokens
    function automatic t_plain_res plain_char(t_lex_state s, logic [7:0] c);
        t_plain_res r;
        t_token     ft;
        logic       pend;
        logic [1:0] k;
        pend = (s.wclass != WC_NONE);
        ft   = make_tok(word_kind(s), s.wlen, s.line);
        k    = char_class(c);
        r.st = s;
        r.n  = 2'd0;
        r.t0 = '0;
        r.t1 = '0;
        if (c == C_QUOTE) begin
            if (pend) begin
                r.t0 = ft;
                r.n  = 2'd1;
            end
            r.st        = clear_word(s);
            r.st.in_str = 1'b1;
            r.st.wlen   = 8'd1;
        end else if (is_space(c)) begin
            if (pend) begin
                r.t0 = ft;
                r.n  = 2'd1;
            end
            r.st = clear_word(s);
        end else if (is_special(c)) begin
            if (pend) begin
                r.t0 = ft;
                r.t1 = make_tok(special_kind(c), 8'd1, s.line);
                r.n  = 2'd2;
            end else begin
                r.t0 = make_tok(special_kind(c), 8'd1, s.line);
                r.n  = 2'd1;
            end
            r.st = clear_word(s);
        end else if (s.wclass == k) begin
            r.st.wlen = sat_inc(s.wlen);
            if (k == WC_LETTER) begin
                r.st.kwp = kw_next(s.kwp, c);
            end
        end else begin
            if (pend) begin
                r.t0 = ft;
                r.n  = 2'd1;
            end
            r.st.wclass = k;
            r.st.wlen   = 8'd1;
            r.st.kwp    = (k == WC_LETTER) ? kw_start(c) : KW_NONE;
        end
        return r;
    endfunction

endpackage

### rtl/keyword_token_lexer_core.sv
// ----------------------------------------------------------------------------
// keyword_token_lexer_core
// character stream tokenizer with keyword, integer, string and comment rules
// ----------------------------------------------------------------------------
// One character (or an end-of-input mark) enters per item; tokens leave one
// per cycle on the output channel while i_ready is high. An item that
// produces at most one token sustains one item per clock while the output
// is ready. An item that produces several tokens sends them out one after
// another; the input stalls while the four-entry token fifo holds more
// than one token, since an item can push up to three tokens at once. The
// first token of an item is valid once the fifo is written: the item waits
// in the input register while the step logic works and the fifo has room.
// ----------------------------------------------------------------------------
module keyword_token_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    // token output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [7:0]  o_lexeme_length,
    output logic [15:0] o_line_number,
    output logic        o_last
);
    import kwl_pkg::*;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_ch;
    logic       r_eoi;

    // lexer state
    t_lex_state r_st;
    t_lex_state step_st;
    t_token [2:0] step_tok;
    logic [1:0] step_n;

    // token fifo
    t_token     r_q [QDEPTH];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;

    logic       advance;
    logic       pop;
    logic [1:0] push_n;

    // the step consumes the held item only when the fifo has room for three
    assign advance = r_in_valid && (r_cnt <= Q_LIMIT);
    assign o_ready = !r_in_valid || advance;
    assign pop     = o_valid && i_ready;
    assign push_n  = advance ? step_n : 2'd0;

    kwl_step u_step (
        .i_st  (r_st),
        .i_ch  (r_ch),
        .i_eoi (r_eoi),
        .o_st  (step_st),
        .o_tok (step_tok),
        .o_n   (step_n)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_ready) begin
            n_in_valid = i_valid;
        end
        n_wr  = r_wr + push_n;
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, push_n} - {2'b0, pop};
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
            r_wr       <= 2'd0;
            r_rd       <= 2'd0;
            r_cnt      <= 3'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_wr       <= n_wr;
            r_rd       <= n_rd;
            r_cnt      <= n_cnt;
            if (advance) begin
                r_st <= step_st;
            end
        end
    end

    // payload: the input character and the queued tokens
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_eoi <= i_end_of_input;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_n) begin
                r_q[r_wr + 2'(i)] <= step_tok[i];
            end
        end
    end

    // head of the fifo drives the output
    assign o_valid         = (r_cnt != 3'd0);
    assign o_token_kind    = r_q[r_rd].kind;
    assign o_lexeme_length = r_q[r_rd].len;
    assign o_line_number   = r_q[r_rd].line;
    assign o_last          = r_q[r_rd].last;

`ifndef SYNTHESIS
    // fifo never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(QDEPTH))
        else $error("token fifo overflow");

    // end of input always closes the item with a done token of length zero
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_DONE |-> o_last && o_lexeme_length == 8'd0)
        else $error("done token not last or nonzero length");

    // end of input leaves no word, string, comment or held slash behind
    a_eoi_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_eoi |=> r_st.wclass == WC_NONE && !r_st.in_str &&
                             !r_st.in_cmt && !r_st.held_slash)
        else $error("state not cleared after end of input");

    // a step never pushes past the fifo depth
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> r_cnt + {1'b0, step_n} <= 3'(QDEPTH))
        else $error("token fifo has no room for the step");
`endif

endmodule

### rtl/kwl_step.sv
// ----------------------------------------------------------------------------
// kwl_step
// one character step: next lexer state and up to three tokens
// ----------------------------------------------------------------------------
module kwl_step (
    input  kwl_pkg::t_lex_state       i_st,
    input  logic [7:0]                i_ch,
    input  logic                      i_eoi,
    output kwl_pkg::t_lex_state       o_st,
    output kwl_pkg::t_token [2:0]     o_tok,
    output logic [1:0]                o_n
);
    import kwl_pkg::*;

    t_lex_state s;
    t_token [2:0] tk;
    logic [1:0] n;
    t_plain_res pc_slash;
    t_plain_res pc_char;
    logic line_end;
    logic counts;
    logic consumed;

    always_comb begin
        s        = i_st;
        tk       = '0;
        n        = 2'd0;
        consumed = 1'b0;
        line_end = (i_ch == C_LF) || (i_ch == C_CR);
        counts   = (i_ch == C_CR) || (i_ch == C_LF && !i_st.prev_cr);

        // a held slash that does not open a comment is an other-class char
        pc_slash = plain_char(i_st, C_SLASH);
        pc_char  = '0;

        if (i_eoi) begin
            if (s.held_slash) begin
                if (pc_slash.n != 2'd0) tk[n] = pc_slash.t0;
                if (pc_slash.n == 2'd2) tk[n + 2'd1] = pc_slash.t1;
                n            = n + pc_slash.n;
                s            = pc_slash.st;
                s.held_slash = 1'b0;
            end
            if (s.in_str) begin
                tk[n]    = make_tok(K_ERR, s.wlen, s.line);
                n        = n + 2'd1;
                s.in_str = 1'b0;
                s.wlen   = 8'd0;
            end
            if (s.wclass != WC_NONE) begin
                tk[n] = make_tok(word_kind(s), s.wlen, s.line);
                n     = n + 2'd1;
            end
            tk[n] = make_tok(K_DONE, 8'd0, s.line);
            n     = n + 2'd1;
            s     = '0;
            s.line = i_st.line;
        end else begin
            if (s.held_slash) begin
                if (i_ch == C_SLASH) begin
                    if (s.wclass != WC_NONE) begin
                        tk[n] = make_tok(word_kind(s), s.wlen, s.line);
                        n     = n + 2'd1;
                    end
                    s        = clear_word(s);
                    s.in_cmt = 1'b1;
                    consumed = 1'b1;
                end else begin
                    if (pc_slash.n != 2'd0) tk[n] = pc_slash.t0;
                    if (pc_slash.n == 2'd2) tk[n + 2'd1] = pc_slash.t1;
                    n = n + pc_slash.n;
                    s = pc_slash.st;
                end
                s.held_slash = 1'b0;
            end
            s.prev_cr = (i_ch == C_CR);
            if (counts && s.line != MAX_LINE) begin
                s.line = s.line + 16'd1;
            end
            pc_char = plain_char(s, i_ch);

            priority if (consumed) begin
                s.in_cmt = 1'b1;
            end else if (s.in_cmt) begin
                if (line_end) s.in_cmt = 1'b0;
            end else if (s.in_str) begin
                if (i_ch == C_QUOTE) begin
                    tk[n]    = make_tok(K_STR, sat_inc(s.wlen), s.line);
                    n        = n + 2'd1;
                    s.in_str = 1'b0;
                    s.wlen   = 8'd0;
                end else if (line_end) begin
                    tk[n]    = make_tok(K_ERR, s.wlen, s.line);
                    n        = n + 2'd1;
                    s.in_str = 1'b0;
                    s.wlen   = 8'd0;
                end else begin
                    s.wlen = sat_inc(s.wlen);
                end
            end else if (i_ch == C_SLASH) begin
                s.held_slash = 1'b1;
            end else begin
                if (pc_char.n != 2'd0) tk[n] = pc_char.t0;
                if (pc_char.n == 2'd2) tk[n + 2'd1] = pc_char.t1;
                n = n + pc_char.n;
                s = pc_char.st;
            end
        end

        // mark the final token of this item
        for (int i = 0; i < 3; i++) begin
            tk[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
        end
    end

    assign o_st  = s;
    assign o_tok = tk;
    assign o_n   = n;

endmodule
